// ===== rtl/core/sha1s_pkg.sv =====
package sha1s_pkg;

   localparam int NUM_WORDS  = 5;
   localparam int NUM_ROUNDS = 80;

   localparam logic [6:0] LAST_ROUND = 7'(NUM_ROUNDS - 1);

   localparam logic [NUM_WORDS-1:0][31:0] CHAIN_INIT = {
      32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
   };

   localparam logic [7:0] PAD_MARKER = 8'h80;

   // control from the byte sequencer to the round unit
   typedef struct packed {
      logic        start;
      logic        init;
      logic [31:0] word;
   } ctrl_type;

   // status from the round unit back to the sequencer
   typedef struct packed {
      logic rounding;
      logic done;
   } stat_type;

   function automatic logic [31:0] round_const(input logic [6:0] rnd);
      logic [31:0] k;
      if (rnd < 7'd20) begin
         k = 32'h5A827999;
      end else if (rnd < 7'd40) begin
         k = 32'h6ED9EBA1;
      end else if (rnd < 7'd60) begin
         k = 32'h8F1BBCDC;
      end else begin
         k = 32'hCA62C1D6;
      end
      return k;
   endfunction

endpackage

// ===== rtl/core/sha1s_req_if.sv =====
interface sha1s_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       has_byte;
   logic       final_req;

   modport source (output valid, output data_byte, output has_byte, output final_req,
                   input ready);
   modport sink (input valid, input data_byte, input has_byte, input final_req,
                 output ready);
endinterface

// ===== rtl/core/sha1s_rsp_if.sv =====
interface sha1s_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  word_index;
   logic        last_word;

   modport source (output valid, output digest_word, output word_index, output last_word,
                   input ready);
   modport sink (input valid, input digest_word, input word_index, input last_word,
                 output ready);
endinterface

// ===== rtl/core/sha1s_round_unit.sv =====
module sha1s_round_unit (
   input  logic                                        clock,
   input  logic                                        reset,
   input  sha1s_pkg::ctrl_type                         ctrl,
   output sha1s_pkg::stat_type                         stat,
   output logic [sha1s_pkg::NUM_WORDS-1:0][31:0]       chain_word
);

   typedef enum logic [2:0] {
      RU_IDLE  = 3'b001,
      RU_ROUND = 3'b010,
      RU_SUM   = 3'b100
   } ru_state_type;

   ru_state_type state_ff;
   logic [6:0]   rnd_ff;
   logic [31:0]  a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [sha1s_pkg::NUM_WORDS-1:0][31:0] chain_ff;

   logic [31:0] f_val;
   logic [31:0] t_val;

   always_comb begin
      if (rnd_ff < 7'd20) begin
         f_val = (b_ff & c_ff) | (~b_ff & d_ff);
      end else if (rnd_ff >= 7'd40 && rnd_ff < 7'd60) begin
         f_val = (b_ff & c_ff) | (b_ff & d_ff) | (c_ff & d_ff);
      end else begin
         f_val = b_ff ^ c_ff ^ d_ff;
      end
      t_val = {a_ff[26:0], a_ff[31:27]} + f_val + e_ff
            + sha1s_pkg::round_const(rnd_ff) + ctrl.word;
   end

   assign stat.rounding = (state_ff == RU_ROUND);
   assign stat.done     = (state_ff == RU_SUM);
   assign chain_word    = chain_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= RU_IDLE;
         rnd_ff   <= '0;
         chain_ff <= sha1s_pkg::CHAIN_INIT;
      end else begin
         case (state_ff)
            RU_IDLE: begin
               if (ctrl.init) begin
                  chain_ff <= sha1s_pkg::CHAIN_INIT;
               end
               if (ctrl.start) begin
                  a_ff     <= chain_ff[0];
                  b_ff     <= chain_ff[1];
                  c_ff     <= chain_ff[2];
                  d_ff     <= chain_ff[3];
                  e_ff     <= chain_ff[4];
                  rnd_ff   <= '0;
                  state_ff <= RU_ROUND;
               end
            end
            RU_ROUND: begin
               a_ff   <= t_val;
               b_ff   <= a_ff;
               c_ff   <= {b_ff[1:0], b_ff[31:2]};
               d_ff   <= c_ff;
               e_ff   <= d_ff;
               rnd_ff <= rnd_ff + 7'd1;
               if (rnd_ff == sha1s_pkg::LAST_ROUND) begin
                  state_ff <= RU_SUM;
               end
            end
            RU_SUM: begin
               chain_ff[0] <= chain_ff[0] + a_ff;
               chain_ff[1] <= chain_ff[1] + b_ff;
               chain_ff[2] <= chain_ff[2] + c_ff;
               chain_ff[3] <= chain_ff[3] + d_ff;
               chain_ff[4] <= chain_ff[4] + e_ff;
               state_ff    <= RU_IDLE;
            end
            default: begin
               state_ff <= RU_IDLE;
            end
         endcase
      end
   end

endmodule

// ===== rtl/core/sha1_stream_hash.sv =====
// sha1 digest over a byte stream
// req_bus carries one item per handshake: data_byte with has_byte, and final_req
// to close the message. bytes are packed big-endian into a 64-byte block and a
// 64-bit bit count runs alongside (it wraps at 2^64).
// a plain byte item is shifted into the block and counted. the item that fills a
// block starts the round unit: 80 rounds at one per cycle, then the chain sum;
// req_bus.ready stays low throughout.
// a final item pads one byte per cycle (0x80, zeros, 8 length bytes) through
// one or two block compressions, then rsp_bus shows the five digest words,
// index 0 first, last_word on index 4.
// rsp_bus holds each word until it is taken; while the receiver stalls, the
// block waits and accepts no new item. after the last word the chain, length
// and fill return to their initial values and req_bus.ready rises again.
// reset (synchronous, active high) puts the block idle and loads the sha1
// initial chain; no clearing pass is needed since every block byte is rewritten
module sha1_stream_hash (
   input  logic        clock,
   input  logic        reset,
   sha1s_req_if.sink   req_bus,
   sha1s_rsp_if.source rsp_bus
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_HASH = 4'b0010,
      ST_PAD  = 4'b0100,
      ST_EMIT = 4'b1000
   } state_type;

   localparam logic [5:0] LAST_FILL = 6'd63;
   localparam logic [5:0] LEN_FILL  = 6'd56;
   localparam logic [2:0] LAST_IDX  = 3'(sha1s_pkg::NUM_WORDS - 1);

   state_type    state_ff, state_in;
   logic [511:0] blk_ff, blk_in;        // block bytes, doubles as schedule line
   logic [5:0]   fill_ff, fill_in;
   logic [63:0]  len_ff, len_in;
   logic         fin_pend_ff, fin_pend_in;
   logic         mark_done_ff, mark_done_in;
   logic         len_phase_ff, len_phase_in;
   logic [2:0]   emit_idx_ff, emit_idx_in;

   sha1s_pkg::ctrl_type ctrl;
   sha1s_pkg::stat_type stat;
   logic [sha1s_pkg::NUM_WORDS-1:0][31:0] chain_word;

   logic [7:0]  pad_byte;
   logic [31:0] sched_mix;
   logic [31:0] sched_word;
   logic        start;
   logic        init;

   sha1s_round_unit u_round (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .stat       (stat),
      .chain_word (chain_word)
   );

   // round t uses word 0 of the line, word 16 is formed from words 13, 8, 2, 0
   assign sched_mix  = blk_ff[95:64] ^ blk_ff[255:224] ^ blk_ff[447:416] ^ blk_ff[511:480];
   assign sched_word = {sched_mix[30:0], sched_mix[31]};

   assign ctrl.start = start;
   assign ctrl.init  = init;
   assign ctrl.word  = blk_ff[511:480];

   // padding byte: marker first, then zeros up to the length field, then the length bytes
   always_comb begin
      if (!mark_done_ff) begin
         pad_byte = sha1s_pkg::PAD_MARKER;
      end else if (len_phase_ff || fill_ff == LEN_FILL) begin
         pad_byte = len_ff[{3'd7 - fill_ff[2:0], 3'b000} +: 8];
      end else begin
         pad_byte = 8'h00;
      end
   end

   assign req_bus.ready       = (state_ff == ST_IDLE);
   assign rsp_bus.valid       = (state_ff == ST_EMIT);
   assign rsp_bus.digest_word = chain_word[emit_idx_ff];
   assign rsp_bus.word_index  = emit_idx_ff;
   assign rsp_bus.last_word   = (emit_idx_ff == LAST_IDX);

   always_comb begin
      state_in     = state_ff;
      blk_in       = blk_ff;
      fill_in      = fill_ff;
      len_in       = len_ff;
      fin_pend_in  = fin_pend_ff;
      mark_done_in = mark_done_ff;
      len_phase_in = len_phase_ff;
      emit_idx_in  = emit_idx_ff;
      start        = 1'b0;
      init         = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               fin_pend_in = req_bus.final_req;
               if (req_bus.has_byte) begin
                  blk_in  = {blk_ff[503:0], req_bus.data_byte};
                  fill_in = fill_ff + 6'd1;
                  len_in  = len_ff + 64'd8;
               end
               // a full block is compressed before any padding
               if (req_bus.has_byte && fill_ff == LAST_FILL) begin
                  start    = 1'b1;
                  state_in = ST_HASH;
               end else if (req_bus.final_req) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            blk_in       = {blk_ff[503:0], pad_byte};
            fill_in      = fill_ff + 6'd1;
            mark_done_in = 1'b1;
            if (mark_done_ff && fill_ff == LEN_FILL) begin
               len_phase_in = 1'b1;
            end
            if (fill_ff == LAST_FILL) begin
               start    = 1'b1;
               state_in = ST_HASH;
            end
         end
         ST_HASH: begin
            if (stat.rounding) begin
               blk_in = {blk_ff[479:0], sched_word};
            end
            if (stat.done) begin
               if (len_phase_ff) begin
                  state_in = ST_EMIT;
               end else if (fin_pend_ff) begin
                  state_in = ST_PAD;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_EMIT: begin
            if (rsp_bus.ready) begin
               if (emit_idx_ff == LAST_IDX) begin
                  // digest delivered: back to the empty message
                  init         = 1'b1;
                  state_in     = ST_IDLE;
                  len_in       = '0;
                  fill_in      = '0;
                  fin_pend_in  = 1'b0;
                  mark_done_in = 1'b0;
                  len_phase_in = 1'b0;
                  emit_idx_in  = '0;
               end else begin
                  emit_idx_in = emit_idx_ff + 3'd1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         len_ff       <= '0;
         fin_pend_ff  <= 1'b0;
         mark_done_ff <= 1'b0;
         len_phase_ff <= 1'b0;
         emit_idx_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         len_ff       <= len_in;
         fin_pend_ff  <= fin_pend_in;
         mark_done_ff <= mark_done_in;
         len_phase_ff <= len_phase_in;
         emit_idx_ff  <= emit_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      blk_ff <= blk_in;
   end

endmodule
